// ----- design/jsu_pkg.sv -----
// types, codes and helper functions shared by the json string unescaper
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DISCARD,
        PH_STR,
        PH_ESC,
        PH_HEX1,
        PH_PAIR_BS,
        PH_PAIR_U,
        PH_HEX2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_DONE,
        KIND_ERR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_EXPECT_QUOTE,
        ERR_UNTERM_STRING,
        ERR_UNTERM_ESCAPE,
        ERR_TRUNC_HEX,
        ERR_BAD_HEX,
        ERR_BAD_LOW_SURR,
        ERR_UNPAIRED,
        ERR_BAD_ESCAPE
    } err_code_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_FF    = 8'h0C;
    localparam logic [7:0] CTL_LF    = 8'h0A;
    localparam logic [7:0] CTL_CR    = 8'h0D;
    localparam logic [7:0] CTL_TAB   = 8'h09;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // results caused by one input word, sent out one per beat
    typedef struct packed {
        logic             valid;
        logic [1:0]       last_idx;
        logic [3:0][7:0]  data;
        kind_t            kind;
        err_code_t        code;
    } res_bundle_t;

    typedef struct packed {
        logic [1:0]       last_idx;
        logic [3:0][7:0]  data;
    } utf8_seq_t;

    // bit 4 set for a byte that is no hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] tmp;
        tmp = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, c[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            tmp = c - 8'h57;
            return {1'b0, tmp[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            tmp = c - 8'h37;
            return {1'b0, tmp[3:0]};
        end
        return 5'h10;
    endfunction

    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
        utf8_seq_t s;
        s = '0;
        if (cp < 21'h80) begin
            s.last_idx = 2'd0;
            s.data[0]  = {1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            s.last_idx = 2'd1;
            s.data[0]  = {3'b110, cp[10:6]};
            s.data[1]  = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            s.last_idx = 2'd2;
            s.data[0]  = {4'b1110, cp[15:12]};
            s.data[1]  = {2'b10, cp[11:6]};
            s.data[2]  = {2'b10, cp[5:0]};
        end else begin
            s.last_idx = 2'd3;
            s.data[0]  = {5'b11110, cp[20:18]};
            s.data[1]  = {2'b10, cp[17:12]};
            s.data[2]  = {2'b10, cp[11:6]};
            s.data[3]  = {2'b10, cp[5:0]};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/jsu_step.sv -----
// decode step: next scanner state and the result bundle for one input word
`default_nettype none

module jsu_step (
    input  wire jsu_pkg::phase_t      phase,
    input  wire logic [15:0]          hex_value,
    input  wire logic [1:0]           hex_cnt,
    input  wire logic [9:0]           high_half,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 end_of_input,
    output jsu_pkg::phase_t           phase_next,
    output logic [15:0]               hex_value_next,
    output logic [1:0]                hex_cnt_next,
    output logic [9:0]                high_half_next,
    output jsu_pkg::res_bundle_t      res
);
    import jsu_pkg::*;

    logic [4:0]  dig;
    logic [15:0] hv_new;
    logic        hex_bad;
    logic        hex_done;
    logic        is_high;
    logic        is_low;
    logic [20:0] cp_pair;
    utf8_seq_t   enc_bmp;
    utf8_seq_t   enc_pair;

    assign dig      = hex_digit(in_byte);
    assign hex_bad  = dig[4];
    assign hv_new   = {hex_value[11:0], dig[3:0]};
    assign hex_done = (hex_cnt == 2'd3);
    assign is_high  = (hv_new[15:10] == SURR_HIGH_TAG);
    assign is_low   = (hv_new[15:10] == SURR_LOW_TAG);
    assign cp_pair  = SUPP_BASE + {1'b0, high_half, hv_new[9:0]};
    assign enc_bmp  = utf8_encode({5'd0, hv_new});
    assign enc_pair = utf8_encode(cp_pair);

    // next state
    always_comb begin
        phase_next     = phase;
        hex_value_next = hex_value;
        hex_cnt_next   = hex_cnt;
        high_half_next = high_half;
        unique case (phase)
            PH_IDLE, PH_DISCARD: begin
                if (!end_of_input) begin
                    if (in_byte == CH_QUOTE) begin
                        phase_next = PH_STR;
                    end else if (phase == PH_IDLE) begin
                        phase_next = PH_DISCARD;
                    end
                end
            end
            PH_STR: begin
                if (end_of_input) begin
                    phase_next = PH_DISCARD;
                end else if (in_byte == CH_QUOTE) begin
                    phase_next = PH_IDLE;
                end else if (in_byte == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC: begin
                if (end_of_input) begin
                    phase_next = PH_DISCARD;
                end else begin
                    case (in_byte) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
                            phase_next = PH_STR;
                        end
                        CH_U: begin
                            phase_next     = PH_HEX1;
                            hex_value_next = '0;
                            hex_cnt_next   = '0;
                        end
                        default: begin
                            phase_next = PH_DISCARD;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (end_of_input || hex_bad) begin
                    phase_next = PH_DISCARD;
                end else begin
                    hex_value_next = hv_new;
                    if (!hex_done) begin
                        hex_cnt_next = hex_cnt + 2'd1;
                    end else begin
                        hex_cnt_next = '0;
                        if (phase == PH_HEX1) begin
                            if (is_high) begin
                                high_half_next = hv_new[9:0];
                                phase_next     = PH_PAIR_BS;
                            end else begin
                                phase_next = PH_STR;
                            end
                        end else if (is_low) begin
                            phase_next = PH_STR;
                        end else begin
                            phase_next = PH_DISCARD;
                        end
                    end
                end
            end
            PH_PAIR_BS: begin
                if (end_of_input || in_byte != CH_BSLASH) begin
                    phase_next = PH_DISCARD;
                end else begin
                    phase_next = PH_PAIR_U;
                end
            end
            PH_PAIR_U: begin
                if (end_of_input || in_byte != CH_U) begin
                    phase_next = PH_DISCARD;
                end else begin
                    phase_next     = PH_HEX2;
                    hex_value_next = '0;
                    hex_cnt_next   = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // results
    always_comb begin
        res          = '0;
        res.kind     = KIND_DATA;
        res.code     = ERR_EXPECT_QUOTE;
        unique case (phase)
            PH_IDLE: begin
                if (!end_of_input && in_byte != CH_QUOTE) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ERR;
                    res.code  = ERR_EXPECT_QUOTE;
                end
            end
            PH_DISCARD: begin
                res.valid = 1'b0;
            end
            PH_STR: begin
                if (end_of_input) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ERR;
                    res.code  = ERR_UNTERM_STRING;
                end else if (in_byte == CH_QUOTE) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_DONE;
                end else if (in_byte != CH_BSLASH) begin
                    res.valid   = 1'b1;
                    res.data[0] = in_byte;
                end
            end
            PH_ESC: begin
                if (end_of_input) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ERR;
                    res.code  = ERR_UNTERM_ESCAPE;
                end else begin
                    res.valid = 1'b1;
                    case (in_byte) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.data[0] = in_byte;
                        CH_B:    res.data[0] = CTL_BS;
                        CH_F:    res.data[0] = CTL_FF;
                        CH_N:    res.data[0] = CTL_LF;
                        CH_R:    res.data[0] = CTL_CR;
                        CH_T:    res.data[0] = CTL_TAB;
                        CH_U:    res.valid   = 1'b0;
                        default: begin
                            res.kind = KIND_ERR;
                            res.code = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (end_of_input) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ERR;
                    res.code  = ERR_TRUNC_HEX;
                end else if (hex_bad) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ERR;
                    res.code  = ERR_BAD_HEX;
                end else if (hex_done) begin
                    if (phase == PH_HEX1) begin
                        if (!is_high) begin
                            res.valid    = 1'b1;
                            res.last_idx = enc_bmp.last_idx;
                            res.data     = enc_bmp.data;
                        end
                    end else if (is_low) begin
                        res.valid    = 1'b1;
                        res.last_idx = enc_pair.last_idx;
                        res.data     = enc_pair.data;
                    end else begin
                        res.valid = 1'b1;
                        res.kind  = KIND_ERR;
                        res.code  = ERR_BAD_LOW_SURR;
                    end
                end
            end
            PH_PAIR_BS: begin
                if (end_of_input || in_byte != CH_BSLASH) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ERR;
                    res.code  = ERR_UNPAIRED;
                end
            end
            PH_PAIR_U: begin
                if (end_of_input || in_byte != CH_U) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ERR;
                    res.code  = ERR_UNPAIRED;
                end
            end
            default: begin
                res.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/json_string_unescape_utf8.sv -----
// top level: json string unescaper with input register and result serializer
//
// Takes the raw bytes of one quoted JSON string token, one word per cycle
// while s_tready is high, and returns the decoded string as UTF-8 bytes,
// then a completion word or an error word. A word goes through an input
// register, is decoded combinationally into a bundle of zero to four
// results, and the bundle register hands them out one per beat. While m_tready
// is high, words causing at most one result flow at one per cycle; a word that
// expands to n UTF-8 bytes holds the bundle register for n beats, so the
// single result port sets the rate for \u escapes (at most three bytes out per
// six bytes in, four per twelve for a surrogate pair). No clearing pass after
// reset.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] in_byte
    input  wire logic         s_tuser,   // [0] end_of_input
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]        m_tuser,   // [1:0] result_kind
    output logic              m_tlast
);
    import jsu_pkg::*;

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      in_byte_reg;
    logic            in_eoi_reg;

    phase_t          phase_reg, phase_next;
    logic [15:0]     hex_value_reg, hex_value_next;
    logic [1:0]      hex_cnt_reg, hex_cnt_next;
    logic [9:0]      high_half_reg, high_half_next;

    logic            b_valid_reg, b_valid_next;
    logic [1:0]      b_idx_reg, b_idx_next;
    logic [1:0]      b_last_reg;
    logic [3:0][7:0] b_data_reg;
    kind_t           b_kind_reg;
    err_code_t       b_code_reg;

    res_bundle_t     res;
    logic            s_fire;
    logic            m_fire;
    logic            b_final;
    logic            out_free;
    logic            in_advance;

    assign b_final    = (b_idx_reg == b_last_reg);
    assign m_fire     = m_tvalid && m_tready;
    assign out_free   = !b_valid_reg || (m_tready && b_final);
    assign in_advance = in_valid_reg && out_free;
    assign s_tready   = !in_valid_reg || in_advance;
    assign s_fire     = s_tvalid && s_tready;

    jsu_step u_step (
        .phase          (phase_reg),
        .hex_value      (hex_value_reg),
        .hex_cnt        (hex_cnt_reg),
        .high_half      (high_half_reg),
        .in_byte        (in_byte_reg),
        .end_of_input   (in_eoi_reg),
        .phase_next     (phase_next),
        .hex_value_next (hex_value_next),
        .hex_cnt_next   (hex_cnt_next),
        .high_half_next (high_half_next),
        .res            (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (in_advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        b_idx_next   = b_idx_reg;
        if (in_advance) begin
            b_valid_next = res.valid;
            b_idx_next   = '0;
        end else if (m_fire) begin
            if (b_final) begin
                b_valid_next = 1'b0;
            end else begin
                b_idx_next = b_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            b_valid_reg   <= 1'b0;
            b_idx_reg     <= '0;
            phase_reg     <= PH_IDLE;
            hex_value_reg <= '0;
            hex_cnt_reg   <= '0;
            high_half_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            b_valid_reg  <= b_valid_next;
            b_idx_reg    <= b_idx_next;
            if (in_advance) begin
                phase_reg     <= phase_next;
                hex_value_reg <= hex_value_next;
                hex_cnt_reg   <= hex_cnt_next;
                high_half_reg <= high_half_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
        if (in_advance) begin
            b_last_reg <= res.last_idx;
            b_data_reg <= res.data;
            b_kind_reg <= res.kind;
            b_code_reg <= res.code;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {5'd0, b_code_reg, b_data_reg[b_idx_reg]};
    assign m_tuser  = b_kind_reg;
    assign m_tlast  = b_final;

    a_ctrl_single_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_DATA) |-> m_tlast)
        else $error("completion or error word not marked last");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_idx_reg <= b_last_reg))
        else $error("result index past end of bundle");

    a_bundle_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("bundle dropped before its last word");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending input word lost");

endmodule

`default_nettype wire

// ----- tb/tb_json_string_unescape_utf8.sv -----
// self-checking testbench for the json string unescaper with utf-8 output
module tb_json_string_unescape_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_WORDS  = 410;

    typedef struct {
        logic [7:0] out_byte;
        kind_t      kind;
        err_code_t  code;
        logic       last;
    } unesc_result_t;

    class unescape_scoreboard;
        phase_t        parse_phase;
        logic [15:0]   hex_acc;
        logic [1:0]    digit_cnt;
        logic [9:0]    high_bits;
        unesc_result_t expected_results[$];
        int            fail_count;
        int            words_checked;
        int            strings_done;
        int            errors_reported;
        logic [7:0]    codes_seen;

        function new();
            parse_phase     = PH_IDLE;
            hex_acc         = '0;
            digit_cnt       = '0;
            high_bits       = '0;
            fail_count      = 0;
            words_checked   = 0;
            strings_done    = 0;
            errors_reported = 0;
            codes_seen      = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [4:0] hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return 5'(c - "0");
            if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
            if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
            return 5'h10;
        endfunction

        function void push(logic [7:0] b, kind_t k, err_code_t e);
            unesc_result_t r;
            r.out_byte = b;
            r.kind     = k;
            r.code     = e;
            r.last     = 1'b0;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void raise(err_code_t e);
            push(8'h00, KIND_ERR, e);
            parse_phase = PH_DISCARD;
        endfunction

        function void put_utf8(logic [20:0] cp);
            if (cp < 21'h80) begin
                push(cp[7:0], KIND_DATA, ERR_EXPECT_QUOTE);
            end else if (cp < 21'h800) begin
                push(8'hC0 | 8'(cp >> 6), KIND_DATA, ERR_EXPECT_QUOTE);
                push(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_EXPECT_QUOTE);
            end else if (cp < 21'h10000) begin
                push(8'hE0 | 8'(cp >> 12), KIND_DATA, ERR_EXPECT_QUOTE);
                push(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_EXPECT_QUOTE);
                push(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_EXPECT_QUOTE);
            end else begin
                push(8'hF0 | 8'(cp >> 18), KIND_DATA, ERR_EXPECT_QUOTE);
                push(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA, ERR_EXPECT_QUOTE);
                push(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_EXPECT_QUOTE);
                push(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_EXPECT_QUOTE);
            end
        endfunction

        // accepted input word: advance the decoder and queue what it yields
        function void note_word(logic [7:0] c, logic eoi);
            int         n0;
            logic [4:0] d;
            n0 = expected_results.size();
            case (parse_phase)
                PH_IDLE, PH_DISCARD: begin
                    if (!eoi) begin
                        if (c == CH_QUOTE) parse_phase = PH_STR;
                        else if (parse_phase == PH_IDLE) raise(ERR_EXPECT_QUOTE);
                    end
                end
                PH_STR: begin
                    if (eoi) begin
                        raise(ERR_UNTERM_STRING);
                    end else if (c == CH_QUOTE) begin
                        push(8'h00, KIND_DONE, ERR_EXPECT_QUOTE);
                        parse_phase = PH_IDLE;
                    end else if (c == CH_BSLASH) begin
                        parse_phase = PH_ESC;
                    end else begin
                        push(c, KIND_DATA, ERR_EXPECT_QUOTE);
                    end
                end
                PH_ESC: begin
                    if (eoi) begin
                        raise(ERR_UNTERM_ESCAPE);
                    end else begin
                        parse_phase = PH_STR;
                        case (c)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: push(c, KIND_DATA, ERR_EXPECT_QUOTE);
                            CH_B: push(CTL_BS, KIND_DATA, ERR_EXPECT_QUOTE);
                            CH_F: push(CTL_FF, KIND_DATA, ERR_EXPECT_QUOTE);
                            CH_N: push(CTL_LF, KIND_DATA, ERR_EXPECT_QUOTE);
                            CH_R: push(CTL_CR, KIND_DATA, ERR_EXPECT_QUOTE);
                            CH_T: push(CTL_TAB, KIND_DATA, ERR_EXPECT_QUOTE);
                            CH_U: begin
                                hex_acc     = '0;
                                digit_cnt   = '0;
                                parse_phase = PH_HEX1;
                            end
                            default: raise(ERR_BAD_ESCAPE);
                        endcase
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    d = hex_nibble(c);
                    if (eoi) begin
                        raise(ERR_TRUNC_HEX);
                    end else if (d[4]) begin
                        raise(ERR_BAD_HEX);
                    end else begin
                        hex_acc = {hex_acc[11:0], d[3:0]};
                        if (digit_cnt != 2'd3) begin
                            digit_cnt = digit_cnt + 2'd1;
                        end else begin
                            digit_cnt = '0;
                            if (parse_phase == PH_HEX1) begin
                                if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                                    high_bits   = hex_acc[9:0];
                                    parse_phase = PH_PAIR_BS;
                                end else begin
                                    put_utf8({5'b0, hex_acc});
                                    parse_phase = PH_STR;
                                end
                            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                                put_utf8(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
                                parse_phase = PH_STR;
                            end else begin
                                raise(ERR_BAD_LOW_SURR);
                            end
                        end
                    end
                end
                PH_PAIR_BS: begin
                    if (eoi || c != CH_BSLASH) raise(ERR_UNPAIRED);
                    else parse_phase = PH_PAIR_U;
                end
                PH_PAIR_U: begin
                    if (eoi || c != CH_U) begin
                        raise(ERR_UNPAIRED);
                    end else begin
                        hex_acc     = '0;
                        digit_cnt   = '0;
                        parse_phase = PH_HEX2;
                    end
                end
                default: parse_phase = PH_IDLE;
            endcase
            if (expected_results.size() > n0) expected_results[$].last = 1'b1;
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                fail_count++;
            end
        endfunction

        // accepted result word: compare with the oldest expectation
        function void check_word(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
            unesc_result_t exp_r;
            if (expected_results.size() == 0) begin
                $error("unexpected result word: tdata %0h tuser %0h tlast %0b",
                       tdata, tuser, tlast);
                fail_count++;
                return;
            end
            exp_r = expected_results.pop_front();
            words_checked++;
            cmp_field("out_byte", 16'(exp_r.out_byte), 16'(tdata[7:0]));
            cmp_field("error_code", 16'(exp_r.code), 16'(tdata[10:8]));
            cmp_field("tdata pad", 16'h0, 16'(tdata[15:11]));
            cmp_field("result_kind", 16'(exp_r.kind), 16'(tuser));
            cmp_field("last", 16'(exp_r.last), 16'(tlast));
            if (exp_r.kind == KIND_DONE) strings_done++;
            if (exp_r.kind == KIND_ERR) begin
                errors_reported++;
                codes_seen[exp_r.code] = 1'b1;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tuser  = 1'b0;    // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [10:8] error_code
    logic [1:0]  m_tuser;            // [1:0] result_kind
    logic        m_tlast;

    unescape_scoreboard sb;
    int burst_left  = 1;
    int total_words = 0;
    int rx_mode     = 0;
    int rx_left     = 0;
    int rx_period   = 2;
    int cycle_count = 0;
    bit paused      = 1'b0;

    json_string_unescape_utf8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            rx_left   = $urandom_range(5, 60);
            rx_period = $urandom_range(2, 8);
        end
        rx_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (rx_left % rx_period == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_json_string_unescape_utf8: errors");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic eoi);
        int  gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(b, eoi);
        total_words++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15)
                                               : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] b;
        logic [4:0] d;
        do begin
            b = 8'($urandom_range(0, 255));
            d = sb.hex_nibble(b);
        end while (!d[4]);
        return b;
    endfunction

    function automatic logic [15:0] pick_bmp();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'($urandom_range(0, 'h7F));
            1: v = 16'($urandom_range('h80, 'h7FF));
            2, 3: begin
                v = 16'($urandom_range('h800, 'hFFFF));
                if (v >= 16'hD800 && v <= 16'hDBFF) v = v ^ 16'h0400;
            end
            4: v = 16'($urandom_range('hDC00, 'hDFFF));
            default: begin
                case ($urandom_range(0, 6))
                    0: v = 16'h0000;
                    1: v = 16'h007F;
                    2: v = 16'h0080;
                    3: v = 16'h07FF;
                    4: v = 16'h0800;
                    5: v = 16'hDFFF;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_hex4(input logic [15:0] v);
        send_word(hex_char(v[15:12]), 1'b0);
        send_word(hex_char(v[11:8]), 1'b0);
        send_word(hex_char(v[7:4]), 1'b0);
        send_word(hex_char(v[3:0]), 1'b0);
    endtask

    task automatic send_uesc(input logic [15:0] v);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_hex4(v);
    endtask

    task automatic send_partial_hex();
        repeat ($urandom_range(0, 3)) send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
        if ($urandom_range(0, 1) != 0) send_word(8'($urandom_range(0, 255)), 1'b1);
        else send_word(pick_nonhex(), 1'b0);
    endtask

    task automatic send_rand_string();
        int          pieces;
        int          fault_at;
        logic [7:0]  b;
        logic [15:0] v;
        pieces   = $urandom_range(0, 6);
        fault_at = ($urandom_range(0, 99) < 30) ? $urandom_range(0, pieces) : -1;
        send_word(CH_QUOTE, 1'b0);
        for (int i = 0; i <= pieces; i++) begin
            if (i == fault_at) begin
                case ($urandom_range(0, 8))
                    0: begin
                        do b = 8'($urandom_range(0, 255));
                        while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F,
                                         CH_N, CH_R, CH_T, CH_U});
                        send_word(CH_BSLASH, 1'b0);
                        send_word(b, 1'b0);
                    end
                    1: begin
                        send_word(CH_BSLASH, 1'b0);
                        send_word(8'($urandom_range(0, 255)), 1'b1);
                    end
                    2, 3: begin
                        send_word(CH_BSLASH, 1'b0);
                        send_word(CH_U, 1'b0);
                        send_partial_hex();
                    end
                    4: begin
                        send_uesc(16'($urandom_range('hD800, 'hDBFF)));
                        do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
                        send_word(b, 1'($urandom_range(0, 1)));
                    end
                    5: begin
                        send_uesc(16'($urandom_range('hD800, 'hDBFF)));
                        send_word(CH_BSLASH, 1'b0);
                        do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                        send_word(b, 1'($urandom_range(0, 1)));
                    end
                    6: begin
                        send_uesc(16'($urandom_range('hD800, 'hDBFF)));
                        do v = 16'($urandom_range(0, 'hFFFF));
                        while (v >= 16'hDC00 && v <= 16'hDFFF);
                        send_uesc(v);
                    end
                    7: begin
                        send_uesc(16'($urandom_range('hD800, 'hDBFF)));
                        send_word(CH_BSLASH, 1'b0);
                        send_word(CH_U, 1'b0);
                        send_partial_hex();
                    end
                    default: send_word(8'($urandom_range(0, 255)), 1'b1);
                endcase
                // trailing bytes, mostly dropped while discarding
                repeat ($urandom_range(0, 3))
                    send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                return;
            end
            if (i == pieces) break;
            case ($urandom_range(0, 6))
                0, 1, 2, 3: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    send_word(b, 1'b0);
                end
                4: begin
                    send_word(CH_BSLASH, 1'b0);
                    case ($urandom_range(0, 7))
                        0: send_word(CH_QUOTE, 1'b0);
                        1: send_word(CH_BSLASH, 1'b0);
                        2: send_word(CH_SLASH, 1'b0);
                        3: send_word(CH_B, 1'b0);
                        4: send_word(CH_F, 1'b0);
                        5: send_word(CH_N, 1'b0);
                        6: send_word(CH_R, 1'b0);
                        default: send_word(CH_T, 1'b0);
                    endcase
                end
                5: send_uesc(pick_bmp());
                default: begin
                    send_uesc(16'($urandom_range('hD800, 'hDBFF)));
                    send_uesc(16'($urandom_range('hDC00, 'hDFFF)));
                end
            endcase
        end
        send_word(CH_QUOTE, 1'b0);
    endtask

    initial begin
        int r;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // end of input while idle, stray byte, end of input while discarding
        send_word(8'hFF, 1'b1);
        send_word("x", 1'b0);
        send_word(8'h00, 1'b1);
        // extreme bytes, an escape and the highest surrogate pair
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word("D", 1'b0);
        send_word("B", 1'b0);
        send_word("F", 1'b0);
        send_word("F", 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word("d", 1'b0);
        send_word("f", 1'b0);
        send_word("f", 1'b0);
        send_word("f", 1'b0);
        send_word(CH_QUOTE, 1'b0);
        // input ends right after a backslash
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(8'h5A, 1'b1);

        while (total_words < RAND_WORDS) begin
            if (!paused && total_words >= RAND_WORDS / 2) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 80) send_rand_string();
            else if (r < 92) send_word(8'($urandom_range(0, 255)), 1'b0);
            else send_word(8'($urandom_range(0, 255)), 1'b1);
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (20) @(posedge aclk);

        $display("run covered %0d input words and %0d result words: %0d strings closed,",
                 total_words, sb.words_checked, sb.strings_done);
        $display("%0d errors reported, error codes seen %b (bit per code)",
                 sb.errors_reported, sb.codes_seen);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("tb_json_string_unescape_utf8: clean");
        end else begin
            $display("tb_json_string_unescape_utf8: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/jsu_pkg.sv
design/jsu_step.sv
design/json_string_unescape_utf8.sv
tb/tb_json_string_unescape_utf8.sv
